[sv/assert_macros.svh]
// assertion macros used by the rtl file
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_LATENCY(name, clk_s, rst_s, ante, n, cons) \
  name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> ##n (cons)) \
    else $error("latency assertion failed");
`else
`define ASSERT_IMPL(name, clk_s, rst_s, ante, cons)
`define ASSERT_LATENCY(name, clk_s, rst_s, ante, n, cons)
`endif
`endif

[sv/tpsi_pkg.sv]
// types, constants and helpers for the tensor pad source index unit
// no dependencies
`default_nettype none
package tpsi_pkg;

  localparam int RANK       = 4;
  localparam int COORD_BITS = 14;
  localparam int NDIM       = 4;

  localparam int IN_COORD_W  = 14;
  localparam int SRC_COORD_W = 12;
  localparam int OFFSET_W    = 48;
  localparam int FIELD_W     = 16;
  localparam int DIFF_W      = FIELD_W + 2;
  localparam int MIRROR_W    = DIFF_W + 1;
  localparam int SIZE_MAX    = 4095;

  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 5;

  localparam logic [1:0] MODE_CONSTANT = 2'd0;
  localparam logic [1:0] MODE_REFLECT  = 2'd1;

  localparam logic [1:0] REG_PAD_MODE    = 2'd0;
  localparam logic [1:0] REG_INPUT_SIZES = 2'd1;
  localparam logic [1:0] REG_PAD_BEFORE  = 2'd2;

  localparam logic [63:0] SIZES_RESET = 64'h0001_0001_0001_0001;

  typedef struct packed {
    logic [IN_COORD_W-1:0] out_coord_0;
    logic [IN_COORD_W-1:0] out_coord_1;
    logic [IN_COORD_W-1:0] out_coord_2;
    logic [IN_COORD_W-1:0] out_coord_3;
  } in_item_t;

  typedef struct packed {
    logic [SRC_COORD_W-1:0] src_coord_0;
    logic [SRC_COORD_W-1:0] src_coord_1;
    logic [SRC_COORD_W-1:0] src_coord_2;
    logic [SRC_COORD_W-1:0] src_coord_3;
    logic [OFFSET_W-1:0]    src_offset;
    logic                   use_pad;
    logic                   range_error;
  } out_item_t;

  // 16-bit field of dimension j, dimension 0 in the top bits
  function automatic logic [FIELD_W-1:0] dim_field(logic [63:0] word, int j);
    dim_field = word[(NDIM-1-j)*FIELD_W +: FIELD_W];
  endfunction

  // clamped size; unused dimensions and zero fields count as size one
  function automatic logic [SRC_COORD_W-1:0] dim_size(logic [63:0] sizes_word, int j);
    logic [FIELD_W-1:0] f;
    f = dim_field(sizes_word, j);
    if (j >= RANK || f == '0) begin
      dim_size = SRC_COORD_W'(1);
    end else if (f > FIELD_W'(SIZE_MAX)) begin
      dim_size = SRC_COORD_W'(SIZE_MAX);
    end else begin
      dim_size = f[SRC_COORD_W-1:0];
    end
  endfunction

  // keep only the low COORD_BITS bits of a coordinate
  function automatic logic [FIELD_W-1:0] mask_coord(logic [IN_COORD_W-1:0] c);
    logic [FIELD_W-1:0] m;
    m = '0;
    for (int b = 0; b < IN_COORD_W; b++) begin
      m[b] = c[b] && (b < COORD_BITS);
    end
    mask_coord = m;
  endfunction

endpackage
`default_nettype wire

[sv/tensor_pad_source_index_unit.sv]
// Throughput: one item per clock; busy never rises, out_valid is one cycle per result.
// Five register stages: coordinate minus pad, mirror and range check, then three
// multiply-add stages of the row-major offset. Synchronous active-low reset clears
// the pipeline valid bits and sets pad_mode 0, every size 1 and every pad 0.
// Depends on tpsi_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module tensor_pad_source_index_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire tpsi_pkg::in_item_t            in_data,
  output logic                               out_valid,
  output tpsi_pkg::out_item_t                out_data,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [tpsi_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [tpsi_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [tpsi_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                               pready
);

  localparam int NDIM = tpsi_pkg::NDIM;
  localparam int SW   = tpsi_pkg::SRC_COORD_W;
  localparam int DW   = tpsi_pkg::DIFF_W;
  localparam int MW   = tpsi_pkg::MIRROR_W;
  localparam int FW   = tpsi_pkg::FIELD_W;
  localparam int A0W  = 2 * SW;
  localparam int A1W  = 3 * SW;
  localparam int OW   = tpsi_pkg::OFFSET_W;

  // configuration registers
  logic [1:0]  pad_mode_r;
  logic [63:0] input_sizes_r;
  logic [63:0] pad_before_r;
  logic        cfg_write;
  logic [1:0]  cfg_sel;

  assign pready    = 1'b1;
  assign busy      = 1'b0;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_sel   = paddr[4:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pad_mode_r    <= tpsi_pkg::MODE_CONSTANT;
      input_sizes_r <= tpsi_pkg::SIZES_RESET;
      pad_before_r  <= '0;
    end else if (cfg_write) begin
      case (cfg_sel)
        tpsi_pkg::REG_PAD_MODE:    pad_mode_r    <= pwdata[1:0];
        tpsi_pkg::REG_INPUT_SIZES: input_sizes_r <= pwdata;
        tpsi_pkg::REG_PAD_BEFORE:  pad_before_r  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      tpsi_pkg::REG_PAD_MODE:    prdata = {62'd0, pad_mode_r};
      tpsi_pkg::REG_INPUT_SIZES: prdata = input_sizes_r;
      tpsi_pkg::REG_PAD_BEFORE:  prdata = pad_before_r;
      default:                   prdata = '0;
    endcase
  end

  logic [SW-1:0] size_w [NDIM];
  always_comb begin
    for (int j = 0; j < NDIM; j++) begin
      size_w[j] = tpsi_pkg::dim_size(input_sizes_r, j);
    end
  end

  // stage 1: coordinate minus leading pad
  logic                 v1_r;
  logic signed [DW-1:0] d1_r   [NDIM];
  logic signed [DW-1:0] d1_nxt [NDIM];
  logic [FW-1:0]        coord_w [NDIM];

  always_comb begin
    coord_w[0] = tpsi_pkg::mask_coord(in_data.out_coord_0);
    coord_w[1] = tpsi_pkg::mask_coord(in_data.out_coord_1);
    coord_w[2] = tpsi_pkg::mask_coord(in_data.out_coord_2);
    coord_w[3] = tpsi_pkg::mask_coord(in_data.out_coord_3);
    for (int j = 0; j < NDIM; j++) begin
      d1_nxt[j] = $signed({2'b00, coord_w[j]})
                - $signed({2'b00, tpsi_pkg::dim_field(pad_before_r, j)});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < NDIM; j++) begin
      d1_r[j] <= d1_nxt[j];
    end
  end

  // stage 2: mirror into the input and check the range
  logic          v2_r;
  logic [SW-1:0] src2_r   [NDIM];
  logic [SW-1:0] src2_nxt [NDIM];
  logic          pad2_r, err2_r;
  logic          pad2_nxt, err2_nxt;
  logic signed [MW-1:0] mir_w   [NDIM];
  logic signed [MW-1:0] size_s  [NDIM];
  logic                 in_rng_w [NDIM];
  logic                 mode_const;
  logic signed [MW-1:0] shift_lo, shift_hi;

  always_comb begin
    mode_const = (pad_mode_r == tpsi_pkg::MODE_CONSTANT);
    shift_lo   = (pad_mode_r == tpsi_pkg::MODE_REFLECT) ? MW'(0) : MW'(1);
    shift_hi   = (pad_mode_r == tpsi_pkg::MODE_REFLECT) ? MW'(2) : MW'(1);
    pad2_nxt   = 1'b0;
    err2_nxt   = 1'b0;
    for (int j = 0; j < NDIM; j++) begin
      size_s[j] = $signed({{(MW-SW){1'b0}}, size_w[j]});
      mir_w[j]  = MW'(d1_r[j]);
      if (!mode_const) begin
        if (d1_r[j] < 0) begin
          mir_w[j] = -MW'(d1_r[j]) - shift_lo;
        end else if (MW'(d1_r[j]) >= size_s[j]) begin
          mir_w[j] = (size_s[j] <<< 1) - MW'(d1_r[j]) - shift_hi;
        end
      end
      in_rng_w[j] = (mir_w[j] >= 0) && (mir_w[j] < size_s[j]);
      if (j < tpsi_pkg::RANK) begin
        src2_nxt[j] = in_rng_w[j] ? mir_w[j][SW-1:0] : '0;
        if (!in_rng_w[j]) begin
          if (mode_const) pad2_nxt = 1'b1;
          else            err2_nxt = 1'b1;
        end
      end else begin
        src2_nxt[j] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < NDIM; j++) begin
      src2_r[j] <= src2_nxt[j];
    end
    pad2_r <= pad2_nxt;
    err2_r <= err2_nxt;
  end

  // stage 3: src0 * size1 + src1
  logic           v3_r;
  logic [SW-1:0]  src3_r [NDIM];
  logic           pad3_r, err3_r;
  logic [A0W-1:0] acc3_r, acc3_nxt;

  assign acc3_nxt = {{SW{1'b0}}, src2_r[0]} * {{SW{1'b0}}, size_w[1]}
                  + {{SW{1'b0}}, src2_r[1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < NDIM; j++) begin
      src3_r[j] <= src2_r[j];
    end
    pad3_r <= pad2_r;
    err3_r <= err2_r;
    acc3_r <= acc3_nxt;
  end

  // stage 4: acc * size2 + src2
  logic           v4_r;
  logic [SW-1:0]  src4_r [NDIM];
  logic           pad4_r, err4_r;
  logic [A1W-1:0] acc4_r, acc4_nxt;

  assign acc4_nxt = {{SW{1'b0}}, acc3_r} * {{A0W{1'b0}}, size_w[2]}
                  + {{A0W{1'b0}}, src3_r[2]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < NDIM; j++) begin
      src4_r[j] <= src3_r[j];
    end
    pad4_r <= pad3_r;
    err4_r <= err3_r;
    acc4_r <= acc4_nxt;
  end

  // stage 5: acc * size3 + src3, zero the coordinates and offset when a flag is raised
  logic                out_valid_r;
  tpsi_pkg::out_item_t out_data_r, out_data_nxt;
  logic [OW-1:0]       offset_w;
  logic                flag_w;

  always_comb begin
    offset_w = {{SW{1'b0}}, acc4_r} * {{A1W{1'b0}}, size_w[3]}
             + {{A1W{1'b0}}, src4_r[3]};
    flag_w   = pad4_r || err4_r;
    out_data_nxt.src_coord_0 = flag_w ? '0 : src4_r[0];
    out_data_nxt.src_coord_1 = flag_w ? '0 : src4_r[1];
    out_data_nxt.src_coord_2 = flag_w ? '0 : src4_r[2];
    out_data_nxt.src_coord_3 = flag_w ? '0 : src4_r[3];
    out_data_nxt.src_offset  = flag_w ? '0 : offset_w;
    out_data_nxt.use_pad     = pad4_r;
    out_data_nxt.range_error = err4_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_LATENCY(a_out_latency, clk, rst_n, start && !busy, 5, out_valid)
  `ASSERT_IMPL(a_no_spurious_out, clk, rst_n, out_valid, $past(start, 5))
  `ASSERT_IMPL(a_flags_exclusive, clk, rst_n, out_valid, !(out_data.use_pad && out_data.range_error))
  `ASSERT_IMPL(a_flag_zero_offset, clk, rst_n, out_valid && (out_data.use_pad || out_data.range_error), out_data.src_offset == 48'd0)

endmodule
`default_nettype wire
